// ----- hw/rtl/ssf_pkg.sv -----
// shared types and constants of the spectral smoothness block
`timescale 1ns / 1ps
package ssf_pkg;

  localparam int MAX_BLOCK_DEF      = 4096;
  localparam int LOG_TABLE_BITS_DEF = 6;
  localparam int CFG_W              = 13;
  localparam int MAG_W              = 32;
  localparam int OUT_W              = 32;
  localparam int LEVEL_W            = 16;
  localparam int MIN_BLOCK          = 8;
  localparam int RESET_BLOCK        = 64;
  localparam int QUEUE_DEPTH        = 8;

  typedef struct packed {
    logic                      in_half;
    logic                      past_edge;
    logic                      nonzero;
    logic                      last;
    logic signed [LEVEL_W-1:0] level;
  } item_t;

endpackage

// ----- hw/rtl/ssf_front.sv -----
// front end: sample counting and log-magnitude pipeline
`timescale 1ns / 1ps
module ssf_front #(
  parameter int MAX_BLOCK      = ssf_pkg::MAX_BLOCK_DEF,
  parameter int LOG_TABLE_BITS = ssf_pkg::LOG_TABLE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_fire_i,
  input  logic [ssf_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ssf_pkg::MAG_W-1:0]  in_data_i,
  input  logic                       pop_i,
  output logic                       push_o,
  output ssf_pkg::item_t             item_o
);

  localparam int IDX_W   = $clog2(MAX_BLOCK);
  localparam int NB_W    = $clog2(MAX_BLOCK + 1);
  localparam int NEFF_W  = (ssf_pkg::CFG_W > NB_W) ? ssf_pkg::CFG_W : NB_W;
  localparam int RST_N   = (ssf_pkg::RESET_BLOCK < MAX_BLOCK) ? ssf_pkg::RESET_BLOCK : MAX_BLOCK;
  localparam int TAB_N   = 1 << LOG_TABLE_BITS;
  localparam int CNT_W   = $clog2(ssf_pkg::QUEUE_DEPTH + 1);
  localparam int L2_W    = 21;
  localparam int PROD_W  = 41;
  localparam logic [NEFF_W-1:0] MIN_N = NEFF_W'(ssf_pkg::MIN_BLOCK);
  localparam logic [NEFF_W-1:0] MAX_N = NEFF_W'(MAX_BLOCK);
  localparam logic signed [19:0] DB_PER_OCTAVE = 20'sd394566;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd8388608);

  typedef struct packed {
    logic in_half;
    logic past_edge;
    logic nonzero;
    logic last;
  } tag_t;

  function automatic logic [15:0] frac_log2(input int k);
    logic [63:0] y;
    logic [17:0] b;
    y = (64'd1 << 30) + (64'(k) << (30 - LOG_TABLE_BITS));
    b = '0;
    for (int i = 0; i < 17; i++) begin
      y = (y * y) >> 30;
      b = b << 1;
      if (y >= (64'd2 << 30)) begin
        b[0] = 1'b1;
        y    = y >> 1;
      end
    end
    frac_log2 = 16'((b + 18'd1) >> 1);
  endfunction

  function automatic logic [4:0] lead_one(input logic [ssf_pkg::MAG_W-1:0] m);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < ssf_pkg::MAG_W; i++) begin
      if (m[i]) p = 5'(i);
    end
    return p;
  endfunction

  logic [15:0] frac_tab [TAB_N];
  for (genvar g = 0; g < TAB_N; g++) begin : g_tab
    assign frac_tab[g] = frac_log2(g);
  end

  logic [IDX_W-1:0] idx_q, idx_d, last_idx_q, half_q;
  logic [NEFF_W-1:0] bl_ext, n_eff;
  logic [CNT_W-1:0] resv_q, resv_d;
  logic accept;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  tag_t t1_q, t2_q, t3_q, t4_q, t5_q, t_in;
  logic [ssf_pkg::MAG_W-1:0] m1_q, m2_q;
  logic [4:0] p2_q, p3_q;
  logic [LOG_TABLE_BITS-1:0] k3_q;
  logic [ssf_pkg::MAG_W-1:0] norm;
  logic signed [L2_W-1:0] l2_q;
  logic signed [PROD_W-1:0] prod_q, rounded;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = resv_q < CNT_W'(ssf_pkg::QUEUE_DEPTH);

  always_comb begin
    bl_ext = NEFF_W'(cfg_data_i);
    if (bl_ext < MIN_N) begin
      n_eff = MIN_N;
    end else if (bl_ext > MAX_N) begin
      n_eff = MAX_N;
    end else begin
      n_eff = bl_ext;
    end
  end

  always_comb begin
    idx_d = (idx_q == last_idx_q) ? '0 : idx_q + IDX_W'(1);
    resv_d = resv_q + CNT_W'(accept) - CNT_W'(pop_i);
    t_in.in_half   = idx_q < half_q;
    t_in.past_edge = idx_q >= IDX_W'(3);
    t_in.nonzero   = in_data_i != '0;
    t_in.last      = idx_q == last_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      last_idx_q <= IDX_W'(RST_N - 1);
      half_q     <= IDX_W'(RST_N / 2);
      resv_q     <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      v4_q       <= 1'b0;
      v5_q       <= 1'b0;
    end else begin
      if (cfg_fire_i) begin
        idx_q      <= '0;
        last_idx_q <= IDX_W'(n_eff - NEFF_W'(1));
        half_q     <= IDX_W'(n_eff >> 1);
      end else if (accept) begin
        idx_q <= idx_d;
      end
      resv_q <= resv_d;
      v1_q   <= accept;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
    end
  end

  assign norm = m2_q << (5'd31 - p2_q);

  always_ff @(posedge clk_i) begin
    t1_q   <= t_in;
    m1_q   <= in_data_i;
    t2_q   <= t1_q;
    m2_q   <= m1_q;
    p2_q   <= lead_one(m1_q);
    t3_q   <= t2_q;
    p3_q   <= p2_q;
    k3_q   <= norm[30 -: LOG_TABLE_BITS];
    t4_q   <= t3_q;
    l2_q   <= t3_q.nonzero ? $signed({~p3_q[4], p3_q[3:0], frac_tab[k3_q]}) : '0;
    t5_q   <= t4_q;
    prod_q <= PROD_W'(l2_q) * PROD_W'(DB_PER_OCTAVE);
  end

  assign rounded = prod_q + ROUND_HALF;

  always_comb begin
    push_o           = v5_q;
    item_o.in_half   = t5_q.in_half;
    item_o.past_edge = t5_q.past_edge;
    item_o.nonzero   = t5_q.nonzero;
    item_o.last      = t5_q.last;
    item_o.level     = rounded[24 +: ssf_pkg::LEVEL_W];
  end

endmodule

// ----- hw/rtl/ssf_queue.sv -----
// small register queue between front and back ends
`timescale 1ns / 1ps
module ssf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ssf_pkg::item_t item_i,
  input  logic           pop_i,
  output ssf_pkg::item_t item_o,
  output logic           empty_o
);

  localparam int DEPTH = ssf_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ssf_pkg::item_t slots [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign empty_o = cnt_q == '0;
  assign item_o  = slots[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wrap_inc(wr_q);
      if (pop_i) rd_q <= wrap_inc(rd_q);
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slots[wr_q] <= item_i;
  end

endmodule

// ----- hw/rtl/ssf_back.sv -----
// back end: curvature term, divide by three and saturating sum
`timescale 1ns / 1ps
module ssf_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_fire_i,
  input  logic                      empty_i,
  input  ssf_pkg::item_t            item_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [ssf_pkg::OUT_W-1:0] out_data_o
);

  localparam int NUM_W  = 18;
  localparam int MAG_W  = 17;
  localparam int Q_W    = 16;
  localparam int TERM_W = 17;
  localparam int RCP_W  = 19;
  localparam int MUL_W  = MAG_W + RCP_W;
  localparam int DIV3_SHIFT = 20;
  localparam logic [RCP_W-1:0] DIV3_RECIP = 19'd349526;
  localparam int SUM_W  = ssf_pkg::OUT_W + 1;
  localparam int LW     = ssf_pkg::LEVEL_W;

  logic adv;
  logic signed [LW-1:0] prev1_q, prev2_q;
  logic [1:0] zflags_q;
  logic signed [ssf_pkg::OUT_W-1:0] acc_q, sat_sum;

  logic b1_valid_q, b1_add_q, b1_last_q;
  logic signed [NUM_W-1:0] b1_num_q, num;
  logic b2_valid_q, b2_add_q, b2_last_q;
  logic signed [TERM_W-1:0] b2_term_q, term;

  logic [NUM_W-1:0] mag;
  logic [MAG_W-1:0] a;
  logic [MUL_W-1:0] qprod;
  logic [Q_W-1:0] q;
  logic signed [SUM_W-1:0] sum;
  logic out_valid_q;
  logic [ssf_pkg::OUT_W-1:0] out_data_q;

  // only a second sum meeting a stalled one holds the pipeline
  assign adv   = !(out_valid_q && !out_ready_i && b2_valid_q && b2_last_q);
  assign pop_o = adv && !empty_i;

  assign num = (NUM_W'(prev1_q) <<< 1) - NUM_W'(prev2_q) - NUM_W'(item_i.level);

  always_comb begin
    mag   = b1_num_q[NUM_W-1] ? NUM_W'(-b1_num_q) : NUM_W'(b1_num_q);
    a     = MAG_W'(mag + NUM_W'(1));
    qprod = MUL_W'(a) * MUL_W'(DIV3_RECIP);
    q     = qprod[DIV3_SHIFT +: Q_W];
    term  = b1_num_q[NUM_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end

  always_comb begin
    sum = SUM_W'(acc_q) + (b2_add_q ? SUM_W'(b2_term_q) : '0);
    if (sum[SUM_W-1] != sum[SUM_W-2]) begin
      sat_sum = sum[SUM_W-1] ? {1'b1, {(ssf_pkg::OUT_W-1){1'b0}}}
                             : {1'b0, {(ssf_pkg::OUT_W-1){1'b1}}};
    end else begin
      sat_sum = sum[ssf_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev1_q     <= '0;
      prev2_q     <= '0;
      zflags_q    <= 2'b11;
      acc_q       <= '0;
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_fire_i) begin
        prev1_q  <= '0;
        prev2_q  <= '0;
        zflags_q <= 2'b11;
        acc_q    <= '0;
      end else begin
        if (pop_o) begin
          if (item_i.last) begin
            prev1_q  <= '0;
            prev2_q  <= '0;
            zflags_q <= 2'b11;
          end else if (item_i.in_half) begin
            prev2_q  <= prev1_q;
            prev1_q  <= item_i.level;
            zflags_q <= {zflags_q[0], !item_i.nonzero};
          end
        end
        if (adv && b2_valid_q) begin
          acc_q <= b2_last_q ? '0 : sat_sum;
        end
      end
      if (adv) begin
        b1_valid_q <= pop_o;
        b2_valid_q <= b1_valid_q;
      end
      if (adv && b2_valid_q && b2_last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_num_q  <= num;
      b1_add_q  <= item_i.in_half && item_i.past_edge && item_i.nonzero && (zflags_q == 2'b00);
      b1_last_q <= item_i.last;
      b2_term_q <= term;
      b2_add_q  <= b1_add_q;
      b2_last_q <= b1_last_q;
    end
    if (adv && b2_valid_q && b2_last_q) begin
      out_data_q <= sat_sum;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- hw/rtl/spectral_smoothness_frame.sv -----
// top level of the spectral smoothness block
// the sum of a block is registered once its last sample has passed the log pipeline, the queue and the back-end stages
// throughput: one sample per cycle, set by the single log pipeline and one accumulate
// per cycle; the input stalls only when eight transfers sit in the log pipeline and queue
// reset: asynchronous, active low; block length returns to 64 and all block state clears
`timescale 1ns / 1ps
module spectral_smoothness_frame #(
  parameter int MAX_BLOCK      = ssf_pkg::MAX_BLOCK_DEF,
  parameter int LOG_TABLE_BITS = ssf_pkg::LOG_TABLE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [ssf_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [ssf_pkg::MAG_W-1:0] s_axis_tdata_i,  // magnitude
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [ssf_pkg::OUT_W-1:0] m_axis_tdata_o   // smoothness
);

  logic cfg_fire, push, pop, empty;
  ssf_pkg::item_t push_item, head_item;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  ssf_front #(
    .MAX_BLOCK      (MAX_BLOCK),
    .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_fire_i (cfg_fire),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_data_i  (s_axis_tdata_i),
    .pop_i      (pop),
    .push_o     (push),
    .item_o     (push_item)
  );

  ssf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .empty_o (empty)
  );

  ssf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_fire_i  (cfg_fire),
    .empty_i     (empty),
    .item_i      (head_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

// ----- hw/rtl/ssf_checker.sv -----
// port-level checks of the spectral smoothness block, bound to the top level
`timescale 1ns / 1ps
module ssf_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      cfg_ready_o,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_o,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [ssf_pkg::OUT_W-1:0] m_axis_tdata_o
);

  // a stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped or changed while stalled");

  // input back-pressure only follows an input transfer
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o))
    else $error("input ready fell without a transfer");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !m_axis_tvalid_o)
    else $error("result valid right after reset");

  // input side open once reset is released
  a_reset_ready: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> s_axis_tready_o && cfg_ready_o)
    else $error("not ready after reset");

endmodule

bind spectral_smoothness_frame ssf_checker u_ssf_checker (.*);

// ----- tb/testbench.sv -----
// self-checking testbench for spectral_smoothness_frame: bit-exact sum prediction, random stalls
`timescale 1ns / 1ps
module testbench;
  import ssf_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TABLE_SIZE = 1 << LOG_TABLE_BITS_DEF;
  localparam longint DB_PER_OCTAVE_Q16 = 394566;
  localparam int NUM_PHASES = 4;
  localparam int SETTINGS_PER_PHASE = 3;
  localparam int RANDOM_LENGTH = -1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [MAG_W-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata_o;

  spectral_smoothness_frame uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // predictor state
  int unsigned frac_log2_q16 [TABLE_SIZE];
  logic [CFG_W-1:0] block_len_reg;
  int unsigned sample_pos;
  int signed level_prev1;
  int signed level_prev2;
  logic [1:0] zero_hist;
  int signed smooth_acc;

  logic [MAG_W-1:0] pending_mags[$];
  logic [OUT_W-1:0] expected_sums[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit in_taken = 1'b0;
  int error_count = 0;
  int idle_cycles = 0;

  int idle_send_plan [NUM_PHASES] = '{0, 60, 0, 17};
  int stall_recv_plan [NUM_PHASES] = '{0, 0, 60, 17};
  int length_plan [NUM_PHASES*SETTINGS_PER_PHASE] =
    '{13, 8, 0, 9, 4096, 7, RANDOM_LENGTH, 17, 4097, RANDOM_LENGTH, RANDOM_LENGTH, 64};

  logic [MAG_W-1:0] directed_mags [24] = '{
    32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
    32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
    32'h5555_5555, 32'h0000_0000, 32'h1234_5678, 32'hFFFF_0000,
    32'h0001_0000, 32'h0000_0021, 32'h0000_0000, 32'h0000_003F,
    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0002,
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0005
  };

  task automatic report_mismatch(input string msg);
    if (error_count < 100)
      $display("%0t ns tb mismatch: %s", $time, msg);
    error_count++;
  endtask

  // 20*log10(mag / 2^16) in Q8.8, mag non-zero
  function automatic logic signed [LEVEL_W-1:0] level_db(input logic [MAG_W-1:0] mag);
    int p;
    int unsigned k;
    longint l2;
    longint scaled;
    p = 31;
    while (p > 0 && !mag[p])
      p--;
    if (p >= LOG_TABLE_BITS_DEF)
      k = (mag >> (p - LOG_TABLE_BITS_DEF)) & (TABLE_SIZE - 1);
    else
      k = (mag << (LOG_TABLE_BITS_DEF - p)) & (TABLE_SIZE - 1);
    l2 = longint'(p - 16) * 65536 + longint'(frac_log2_q16[k]);
    scaled = (l2 * DB_PER_OCTAVE_Q16 + (longint'(1) << 23)) >>> 24;
    return scaled[LEVEL_W-1:0];
  endfunction

  function automatic int signed div3_nearest(input int signed v);
    if (v >= 0)
      return (v + 1) / 3;
    return -((-v + 1) / 3);
  endfunction

  function automatic int unsigned effective_length(input logic [CFG_W-1:0] len);
    if (len < MIN_BLOCK)
      return MIN_BLOCK;
    if (len > MAX_BLOCK_DEF)
      return MAX_BLOCK_DEF;
    return len;
  endfunction

  task automatic smooth_restart();
    sample_pos = 0;
    level_prev1 = 0;
    level_prev2 = 0;
    zero_hist = 2'b11;
    smooth_acc = 0;
  endtask

  task automatic smooth_take_sample(input logic [MAG_W-1:0] mag);
    int unsigned n_eff;
    logic nz;
    int signed cur;
    int signed term;
    longint total;
    n_eff = effective_length(block_len_reg);
    if (sample_pos < n_eff / 2) begin
      nz = (mag != 0);
      cur = nz ? int'(level_db(mag)) : 0;
      if (sample_pos >= 3 && nz && zero_hist == 2'b00) begin
        term = div3_nearest(2 * level_prev1 - level_prev2 - cur);
        total = longint'(smooth_acc) + longint'(term);
        if (total > longint'(32'sh7FFF_FFFF))
          total = longint'(32'sh7FFF_FFFF);
        if (total < -longint'(64'sd2147483648))
          total = -longint'(64'sd2147483648);
        smooth_acc = int'(total);
      end
      level_prev2 = level_prev1;
      level_prev1 = cur;
      zero_hist = {zero_hist[0], !nz};
    end
    sample_pos++;
    if (sample_pos >= n_eff) begin
      expected_sums.push_back(smooth_acc);
      smooth_restart();
    end
  endtask

  function automatic logic [MAG_W-1:0] rand_magnitude();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom_range(1, 63);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic write_block_length(input int value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= CFG_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // all samples taken, all sums back, then let the pipeline drain
  task automatic settle();
    while (pending_mags.size() != 0 || s_axis_tvalid_i)
      @(negedge clk_i);
    while (expected_sums.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || in_taken) begin
        if (pending_mags.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= pending_mags.pop_front();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    logic [OUT_W-1:0] want;
    logic cfg_taken;
    logic out_taken;
    if (rst_ni) begin
      in_taken = s_axis_tvalid_i && s_axis_tready_o;
      cfg_taken = cfg_valid_i && cfg_ready_o;
      out_taken = m_axis_tvalid_o && m_axis_tready_i;
      if (cfg_taken) begin
        block_len_reg = cfg_data_i;
        smooth_restart();
      end
      if (in_taken)
        smooth_take_sample(s_axis_tdata_i);
      if (out_taken) begin
        if (expected_sums.size() == 0) begin
          report_mismatch($sformatf("smoothness %0d with no sum pending",
                                    $signed(m_axis_tdata_o)));
        end else begin
          want = expected_sums.pop_front();
          if (m_axis_tdata_o !== want)
            report_mismatch($sformatf("smoothness expected %0d got %0d",
                                      $signed(want), $signed(m_axis_tdata_o)));
        end
      end
      if (in_taken || cfg_taken || out_taken)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    longint unsigned y;
    int unsigned bits;
    int len_val;
    int unsigned n_eff;
    int n_items;

    // log2(1 + k/64) in Q0.16 by repeated squaring
    for (int k = 0; k < TABLE_SIZE; k++) begin
      y = (longint'(1) << 30) + (longint'(k) << (30 - LOG_TABLE_BITS_DEF));
      bits = 0;
      for (int i = 0; i < 17; i++) begin
        y = (y * y) >> 30;
        bits = bits << 1;
        if (y >= (longint'(2) << 30)) begin
          bits = bits | 1;
          y = y >> 1;
        end
      end
      frac_log2_q16[k] = (bits + 1) >> 1;
    end
    block_len_reg = RESET_BLOCK;
    smooth_restart();

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // one block at the reset length
    repeat (RESET_BLOCK) pending_mags.push_back(rand_magnitude());
    settle();

    write_block_length(12);
    foreach (directed_mags[i])
      pending_mags.push_back(directed_mags[i]);
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct = idle_send_plan[ph];
      recv_stall_pct = stall_recv_plan[ph];
      for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
        len_val = length_plan[ph * SETTINGS_PER_PHASE + s];
        if (len_val == RANDOM_LENGTH)
          len_val = $urandom_range(0, 40);
        write_block_length(len_val);
        n_eff = effective_length(CFG_W'(len_val));
        // partial tail left over so the next write restarts a block in progress
        if (n_eff >= 1024)
          n_items = 40;
        else
          n_items = $urandom_range(2, 4) * n_eff + $urandom_range(0, n_eff - 1);
        repeat (n_items) pending_mags.push_back(rand_magnitude());
        settle();
      end
    end

    // oversize length clamps to the largest block, so no sum within a short run
    write_block_length((1 << CFG_W) - 1);
    repeat (40) pending_mags.push_back(rand_magnitude());
    settle();

    if (error_count == 0 && expected_sums.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
